@@ rtl/bmpf_pkg.sv @@
// Package: constants, types and elaboration-time threshold table for the bar meter.
`timescale 1ns / 1ps
`default_nettype none

package bmpf_pkg;

  localparam int COLUMNS     = 64;
  localparam int ROWS        = 32;
  localparam int FADE_LEVELS = 32;

  localparam int COL_W   = 6;
  localparam int LEVEL_W = 17;
  localparam int ROW_W   = 6;
  localparam int SHADE_W = 5;
  localparam int INT_W   = 6;
  localparam int FRAC_W  = 8;
  localparam int POS_W   = 14;
  localparam int STEP_W  = 14;

  localparam int COL_AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [STEP_W-1:0] FALL_STEP_RESET = STEP_W'(683);
  localparam logic [ROW_W-1:0]  ROWS_V          = ROW_W'(ROWS);
  localparam logic [INT_W-1:0]  FADE_LEVELS_V   = INT_W'(FADE_LEVELS);
  localparam logic [POS_W:0]    POS_CAP         = (POS_W + 1)'(ROWS * (1 << FRAC_W));

  // Stored state of one column.
  typedef struct packed {
    logic [POS_W-1:0] fall_position;
    logic [ROW_W-1:0] marker_row;
    logic [INT_W-1:0] marker_intensity;
  } col_state_t;

  localparam col_state_t COL_STATE_RESET = '{
    fall_position:    '0,
    marker_row:       ROWS_V,
    marker_intensity: '0
  };

  typedef struct packed {
    logic load;   // capture the accepted input beat
    logic cmp;    // threshold compare and state read
    logic calc;   // update state and load the result register
  } bmpf_cmd_t;

  typedef struct packed {
    logic out_stall;  // result register holds a beat that is not yet taken
  } bmpf_status_t;

  // log2(n) with 16 fraction bits; fraction by repeated squaring of the mantissa.
  function automatic logic [31:0] log2_q16(input int unsigned n);
    int unsigned k;
    logic [63:0] m;
    logic [31:0] frac;
    k = 0;
    frac = '0;
    if (n == 0) begin
      return 32'd0;
    end
    for (int i = 0; i < 31; i++) begin
      if ((n >> (k + 1)) != 0) begin
        k = k + 1;
      end
    end
    m = (64'(n) << 30) >> k;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 32'd1;
      end
    end
    return (32'(k) << 16) | frac;
  endfunction

  localparam logic [31:0] LOG_DEN_RAW = log2_q16(ROWS + 2);
  localparam logic [63:0] LOG_DEN     = (LOG_DEN_RAW == 0) ? 64'd1 : 64'(LOG_DEN_RAW);

  // Threshold for z blank rows; a level at or above it fills the bar to that row.
  function automatic logic [LEVEL_W-1:0] thr_value(input int unsigned z);
    logic [63:0] q;
    q = (64'(log2_q16(z + 1)) << 16) / LOG_DEN;
    if (q >= 64'd65536) begin
      return '0;
    end
    return LEVEL_W'(64'd65536 - q);
  endfunction

endpackage

`default_nettype wire

@@ rtl/bmpf_if.sv @@
// Stream interfaces for the level input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface bmpf_in_if;
  import bmpf_pkg::*;
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   column;
  logic [LEVEL_W-1:0] level;
  modport source (output valid, output column, output level, input ready);
  modport sink   (input valid, input column, input level, output ready);
endinterface

interface bmpf_out_if;
  import bmpf_pkg::*;
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   bar_row;
  logic [ROW_W-1:0]   peak_row;
  logic               fade_visible;
  logic [ROW_W-1:0]   fade_row;
  logic [SHADE_W-1:0] fade_level;
  modport source (output valid, output bar_row, output peak_row, output fade_visible,
                  output fade_row, output fade_level, input ready);
  modport sink   (input valid, input bar_row, input peak_row, input fade_visible,
                  input fade_row, input fade_level, output ready);
endinterface

`default_nettype wire

@@ rtl/bmpf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bmpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                             wr_data,
  input  wire logic                                         rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bmpf_ctrl.sv @@
// Controller state machine: sequences accept, compare/read and update for one beat.
`timescale 1ns / 1ps
`default_nettype none

module bmpf_ctrl import bmpf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire bmpf_status_t status,
  output bmpf_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_CALC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        // Wait here while the previous result still sits in the output register.
        if (!status.out_stall) begin
          cmd.calc  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/bmpf_datapath.sv @@
// Datapath: quantizer, per-column state RAM, fall and fade update, result register.
`timescale 1ns / 1ps
`default_nettype none

module bmpf_datapath import bmpf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bmpf_cmd_t          cmd,
  output bmpf_status_t            status,
  input  wire logic               cfg_we,
  input  wire logic [STEP_W-1:0]  cfg_wdata,
  input  wire logic [COL_W-1:0]   in_column,
  input  wire logic [LEVEL_W-1:0] in_level,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_bar_row,
  output logic [ROW_W-1:0]        out_peak_row,
  output logic                    out_fade_visible,
  output logic [ROW_W-1:0]        out_fade_row,
  output logic [SHADE_W-1:0]      out_fade_level
);

  logic [STEP_W-1:0]  fall_step_r;
  logic [COL_W-1:0]   col_r;
  logic [LEVEL_W-1:0] level_r;
  logic [ROWS-1:0]    hit_r;
  logic [COLUMNS-1:0] seen_r;
  logic               entry_valid_r;
  logic               out_valid_r;
  logic [ROW_W-1:0]   bar_row_r, peak_row_r, fade_row_r;
  logic               fade_visible_r;
  logic [SHADE_W-1:0] fade_level_r;

  logic [ROWS-1:0]    hit_nxt;
  logic [COL_AW-1:0]  addr;
  logic               in_range;
  logic [$bits(col_state_t)-1:0] rd_data;
  col_state_t         cur, upd;
  logic [ROW_W-1:0]   y_q, y_fin;
  logic [POS_W-1:0]   y_pos, pos_new;
  logic [POS_W:0]     pos_sum;
  logic [ROW_W-1:0]   mrow;
  logic [INT_W-1:0]   mint;
  logic               vis;
  logic [ROW_W-1:0]   frow;
  logic [SHADE_W-1:0] flev;

  assign addr     = COL_AW'(col_r);
  assign in_range = (32'(col_r) < 32'(COLUMNS));

  // A level below threshold z means at least z+1 blank rows; hits form a prefix.
  for (genvar g = 0; g < ROWS; g++) begin : g_thr
    localparam logic [LEVEL_W-1:0] THR = thr_value(g);
    assign hit_nxt[g] = (level_r < THR);
  end

  bmpf_ram #(
    .WIDTH ($bits(col_state_t)),
    .DEPTH (COLUMNS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (cmd.calc && in_range),
    .wr_addr (addr),
    .wr_data (upd),
    .rd_en   (cmd.cmp),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_comb begin
    cur   = entry_valid_r ? col_state_t'(rd_data) : COL_STATE_RESET;
    y_q   = ROW_W'($countones(hit_r));
    y_pos = POS_W'({y_q, {FRAC_W{1'b0}}});

    pos_sum = {1'b0, cur.fall_position} + {1'b0, fall_step_r};
    if (y_pos > cur.fall_position) begin
      pos_new = (pos_sum > POS_CAP) ? POS_CAP[POS_W-1:0] : pos_sum[POS_W-1:0];
      y_fin   = ROW_W'(pos_new[POS_W-1:FRAC_W]);
    end else begin
      pos_new = y_pos;
      y_fin   = y_q;
    end

    mrow = cur.marker_row;
    mint = cur.marker_intensity;
    if (y_fin <= mrow) begin
      mrow = y_fin;
      mint = FADE_LEVELS_V;
    end
    vis  = 1'b0;
    frow = ROWS_V;
    flev = '0;
    if (mint != '0) begin
      mint = mint - INT_W'(1);
      if (mrow < ROWS_V) begin
        vis  = 1'b1;
        frow = mrow;
        flev = mint[SHADE_W-1:0];
      end
    end
    if (mint == '0) begin
      mrow = ROWS_V;
    end

    upd.fall_position    = pos_new;
    upd.marker_row       = mrow;
    upd.marker_intensity = mint;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_step_r <= FALL_STEP_RESET;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fall_step_r <= cfg_wdata;
      end
      if (cmd.calc && in_range) begin
        seen_r[addr] <= 1'b1;
      end
      if (cmd.calc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r   <= in_column;
      level_r <= in_level;
    end
    if (cmd.cmp) begin
      hit_r         <= hit_nxt;
      entry_valid_r <= in_range && seen_r[addr];
    end
    if (cmd.calc) begin
      if (in_range) begin
        bar_row_r      <= y_fin;
        peak_row_r     <= ROW_W'(pos_new[POS_W-1:FRAC_W]);
        fade_visible_r <= vis;
        fade_row_r     <= frow;
        fade_level_r   <= flev;
      end else begin
        bar_row_r      <= ROWS_V;
        peak_row_r     <= ROWS_V;
        fade_visible_r <= 1'b0;
        fade_row_r     <= ROWS_V;
        fade_level_r   <= '0;
      end
    end
  end

  assign status.out_stall = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_bar_row      = bar_row_r;
  assign out_peak_row     = peak_row_r;
  assign out_fade_visible = fade_visible_r;
  assign out_fade_row     = fade_row_r;
  assign out_fade_level   = fade_level_r;

endmodule

`default_nettype wire

@@ rtl/bar_meter_peak_fall_fade_unit.sv @@
// Top level of the spectrum bar meter with falling peak and fading marker.
// Each input beat carries a column number and its level; each produces one result
// beat with the bar row, peak row and fade marker. The block works on one beat at a
// time: a beat passes through three steps in order (capture at the accepting edge,
// threshold compare with state RAM read, update with state RAM write and load of the
// result register), and out_valid is registered and rises with that load. No new
// beat is taken before the last one is through, because of the read-modify-write of
// the per-column state RAM. A new beat is accepted while a finished result waits in
// the output register; the update stalls only if that register is still full and not
// being taken. Column state comes out of reset at once through per-column valid bits,
// with no clearing pass. fall_step is to be written through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module bar_meter_peak_fall_fade_unit import bmpf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [STEP_W-1:0] cfg_wdata,
  bmpf_in_if.sink                in_ch,
  bmpf_out_if.source             out_ch
);

  bmpf_cmd_t    cmd;
  bmpf_status_t status;

  bmpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bmpf_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_column        (in_ch.column),
    .in_level         (in_ch.level),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_bar_row      (out_ch.bar_row),
    .out_peak_row     (out_ch.peak_row),
    .out_fade_visible (out_ch.fade_visible),
    .out_fade_row     (out_ch.fade_row),
    .out_fade_level   (out_ch.fade_level)
  );

endmodule

`default_nettype wire

@@ rtl/bmpf_checker.sv @@
// Port-level assertions for the bar meter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bmpf_checker import bmpf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [ROW_W-1:0]   bar_row,
  input wire logic [ROW_W-1:0]   peak_row,
  input wire logic               fade_visible,
  input wire logic [ROW_W-1:0]   fade_row,
  input wire logic [SHADE_W-1:0] fade_level
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bar_row) && $stable(peak_row)
      && $stable(fade_visible) && $stable(fade_row) && $stable(fade_level))
    else $error("result beat changed while stalled");

  // One beat at a time: no acceptance right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // The shown bar is always the integer part of the stored position.
  a_bar_is_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bar_row == peak_row)
    else $error("bar row differs from peak row");

  // A hidden marker reports the empty row and the darkest shade.
  a_hidden_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !fade_visible |-> fade_row == ROWS_V && fade_level == '0)
    else $error("hidden fade marker with nonempty fields");

endmodule

bind bar_meter_peak_fall_fade_unit bmpf_checker u_bmpf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .bar_row      (out_ch.bar_row),
  .peak_row     (out_ch.peak_row),
  .fade_visible (out_ch.fade_visible),
  .fade_row     (out_ch.fade_row),
  .fade_level   (out_ch.fade_level)
);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the bar meter: random column levels, falling peaks and fade markers.
`timescale 1ns / 1ps

module testbench;
  import bmpf_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [LEVEL_W-1:0] level;
  } level_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]   bar_row;
    logic [ROW_W-1:0]   peak_row;
    logic               fade_visible;
    logic [ROW_W-1:0]   fade_row;
    logic [SHADE_W-1:0] fade_level;
  } bar_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;

  bmpf_in_if  lvl_ch();
  bmpf_out_if bar_ch();

  bar_meter_peak_fall_fade_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (lvl_ch),
    .out_ch    (bar_ch)
  );

  // Shadow copy of the block's per-column state and its fall step register.
  int unsigned       row_threshold [0:ROWS];
  logic [STEP_W-1:0] step_q8;
  logic [POS_W-1:0]  fall_q8 [COLUMNS];
  logic [ROW_W-1:0]  marker_at [COLUMNS];
  logic [INT_W-1:0]  marker_shade [COLUMNS];

  level_beat_t level_beats_q [$];
  bar_result_t bar_expect_q [$];

  int beats_queued;
  int results_seen;
  int mismatches;
  int idle_pct;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // log2(n) with 16 fraction bits; the fraction comes from squaring a mantissa with 30 fraction bits.
  function automatic longint unsigned log2_fix16(input int unsigned n);
    int unsigned     k;
    longint unsigned mant;
    longint unsigned frac;
    k = 0;
    frac = 0;
    if (n == 0) begin
      return 0;
    end
    for (int b = 0; b < 32; b++) begin
      if (n[b]) begin
        k = b;
      end
    end
    mant = {32'd0, n};
    mant = (mant << 30) >> k;
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= 64'h8000_0000) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    return ({32'd0, k} << 16) | frac;
  endfunction

  function automatic void build_thresholds();
    longint unsigned den;
    longint unsigned q;
    den = log2_fix16(ROWS + 2);
    if (den == 0) begin
      den = 1;
    end
    for (int z = 0; z < ROWS; z++) begin
      q = (log2_fix16(z + 1) << 16) / den;
      row_threshold[z] = (q >= 65536) ? 0 : int'(65536 - q);
    end
    row_threshold[ROWS] = 0;
  endfunction

  function automatic bar_result_t predict_bar(input logic [COL_W-1:0] col,
                                              input logic [LEVEL_W-1:0] lvl);
    bar_result_t res;
    int unsigned y;
    int unsigned pos;
    res.bar_row      = ROWS_V;
    res.peak_row     = ROWS_V;
    res.fade_visible = 1'b0;
    res.fade_row     = ROWS_V;
    res.fade_level   = '0;
    if (col >= COLUMNS) begin
      return res;
    end
    y = 0;
    while (y < ROWS && lvl < row_threshold[y]) begin
      y++;
    end
    // A lower bar falls from the stored position; a higher one is taken at once.
    pos = fall_q8[col];
    if ((y << FRAC_W) > pos) begin
      pos = pos + step_q8;
      if (pos > (ROWS << FRAC_W)) begin
        pos = ROWS << FRAC_W;
      end
      y = pos >> FRAC_W;
    end else begin
      pos = y << FRAC_W;
    end
    fall_q8[col] = POS_W'(pos);
    if (y <= marker_at[col]) begin
      marker_at[col]    = ROW_W'(y);
      marker_shade[col] = FADE_LEVELS_V;
    end
    if (marker_shade[col] != 0) begin
      marker_shade[col] = marker_shade[col] - 1'b1;
      if (marker_at[col] < ROWS) begin
        res.fade_visible = 1'b1;
        res.fade_row     = marker_at[col];
        res.fade_level   = SHADE_W'(marker_shade[col]);
      end
    end
    if (marker_shade[col] == 0) begin
      marker_at[col] = ROWS_V;
    end
    res.bar_row  = ROW_W'(y);
    res.peak_row = ROW_W'(pos >> FRAC_W);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: predicts each accepted beat and presents the next pending one.
  always @(posedge clk) begin
    level_beat_t nxt;
    if (!rst_n) begin
      lvl_ch.valid <= 1'b0;
    end else begin
      if (lvl_ch.valid && lvl_ch.ready) begin
        bar_expect_q.push_back(predict_bar(lvl_ch.column, lvl_ch.level));
      end
      if (!lvl_ch.valid || lvl_ch.ready) begin
        if (level_beats_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = level_beats_q.pop_front();
          lvl_ch.valid  <= 1'b1;
          lvl_ch.column <= nxt.column;
          lvl_ch.level  <= nxt.level;
        end else begin
          lvl_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel at random and checks every result beat.
  always @(posedge clk) begin
    bar_result_t want;
    if (!rst_n) begin
      bar_ch.ready <= 1'b0;
    end else begin
      bar_ch.ready <= ($urandom_range(99) >= idle_pct);
      if (bar_ch.valid && bar_ch.ready) begin
        results_seen++;
        if (bar_expect_q.size() == 0) begin
          $display("%0t: result beat with none expected, actual bar %0d peak %0d", $time,
                   bar_ch.bar_row, bar_ch.peak_row);
          mismatches++;
        end else begin
          want = bar_expect_q.pop_front();
          check_field("bar_row", want.bar_row, bar_ch.bar_row);
          check_field("peak_row", want.peak_row, bar_ch.peak_row);
          check_field("fade_visible", want.fade_visible, bar_ch.fade_visible);
          check_field("fade_row", want.fade_row, bar_ch.fade_row);
          check_field("fade_level", want.fade_level, bar_ch.fade_level);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (lvl_ch.valid && lvl_ch.ready) || (bar_ch.valid && bar_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("bar_meter_peak_fall_fade_unit verification failed");
        $finish;
      end
    end
  end

  task automatic queue_beat(input int col, input int lvl);
    level_beats_q.push_back('{column: COL_W'(col), level: LEVEL_W'(lvl)});
    beats_queued++;
  endtask

  function automatic int pick_level();
    int unsigned r;
    int unsigned z;
    r = $urandom_range(99);
    z = $urandom_range(ROWS - 1);
    if (r < 40) begin
      return int'(row_threshold[z] + $urandom_range(2) - 1);
    end else if (r < 70) begin
      return $urandom_range(65536);
    end else if (r < 80) begin
      return $urandom_range(131071, 65537);
    end else if (r < 90) begin
      return $urandom_range(2000);
    end
    return $urandom_range(1) ? 65536 : 0;
  endfunction

  task automatic queue_random(input int count);
    int added;
    int kind;
    int col;
    int run;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(19);
      if (kind == 0) begin
        // A full bar followed by a long quiet stretch lets the marker run out.
        col = $urandom_range(COLUMNS - 1);
        queue_beat(col, 65536);
        for (int i = 0; i < FADE_LEVELS + 3; i++) begin
          queue_beat(col, $urandom_range(500));
        end
        added += FADE_LEVELS + 4;
      end else if (kind < 12) begin
        // A peak on a busy column, then whatever follows it.
        col = $urandom_range(3);
        run = $urandom_range(8, 2);
        queue_beat(col, $urandom_range(65536, 20000));
        for (int i = 0; i < run; i++) begin
          queue_beat(col, pick_level());
        end
        added += run + 1;
      end else begin
        queue_beat($urandom_range(COLUMNS - 1), pick_level());
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (results_seen < beats_queued);
  endtask

  task automatic write_fall_step(input logic [STEP_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    step_q8 = value;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    lvl_ch.valid  = 1'b0;
    lvl_ch.column = '0;
    lvl_ch.level  = '0;
    bar_ch.ready  = 1'b0;
    idle_pct      = 14;
    beats_queued  = 0;
    results_seen  = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    build_thresholds();
    step_q8 = FALL_STEP_RESET;
    for (int c = 0; c < COLUMNS; c++) begin
      fall_q8[c]      = '0;
      marker_at[c]    = ROWS_V;
      marker_shade[c] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Default fall step: empty and full bars, falling, threshold edges, levels above one.
    queue_beat(0, 0);
    queue_beat(0, 65536);
    queue_beat(0, 0);
    queue_beat(0, 0);
    queue_beat(0, 0);
    queue_beat(63, 131071);
    queue_beat(63, 65537);
    queue_beat(42, row_threshold[5]);
    queue_beat(42, row_threshold[5] - 1);
    queue_beat(21, row_threshold[ROWS - 1]);
    queue_beat(21, row_threshold[ROWS - 1] - 1);
    queue_beat(21, 1);
    queue_beat(1, row_threshold[10]);
    queue_beat(1, row_threshold[3]);
    queue_beat(1, 0);
    wait_drained();

    // With no fall step a lower bar holds its position.
    write_fall_step('0);
    queue_beat(2, 65536);
    queue_beat(2, 0);
    queue_beat(2, 0);
    queue_beat(0, 0);
    queue_beat(2, row_threshold[8]);
    wait_drained();

    write_fall_step({STEP_W{1'b1}});
    queue_beat(3, 65536);
    queue_beat(3, 0);
    queue_beat(3, 0);
    queue_random(100);
    wait_drained();

    write_fall_step(STEP_W'(1));
    queue_random(100);
    wait_drained();

    write_fall_step(STEP_W'($urandom_range(16382, 2)));
    idle_pct = 0;
    queue_random(120);
    wait_drained();
    idle_pct = 14;
    queue_random(80);
    wait_drained();

    write_fall_step(STEP_W'(256));
    queue_random(100);
    wait_drained();
    repeat (10) @(posedge clk);

    if (bar_expect_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, bar_expect_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("bar_meter_peak_fall_fade_unit verification clean");
    end else begin
      $display("bar_meter_peak_fall_fade_unit verification failed");
    end
    $finish;
  end

endmodule
